/* hdl/draw_hold_erase_envelope_defines.svh */
// ----------------------------------------------------------------------------
// Draw/hold/erase envelope assertion macros
// Shared property forms for the envelope RTL. Each macro expects clk and rst
// to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef DRAW_HOLD_ERASE_ENVELOPE_DEFINES_SVH
`define DRAW_HOLD_ERASE_ENVELOPE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DHE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/dhe_pkg.sv */
// ----------------------------------------------------------------------------
// Draw/hold/erase envelope package
// Widths and fixed constants shared by the envelope modules.
// ----------------------------------------------------------------------------
package dhe_pkg;

  localparam int ADV_W   = 16;  // tick advance, ms
  localparam int DUR_W   = 16;  // phase durations, ms
  localparam int TIME_W  = 17;  // saturating phase timer
  localparam int LEVEL_W = 17;  // Q1.16 level, 65536 is one
  localparam int PHASE_W = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Square of the ratio and full cube widths.
  localparam int SQ_W   = 2 * LEVEL_W;
  localparam int CUBE_W = SQ_W + LEVEL_W;

  localparam logic [LEVEL_W-1:0] ONE_Q16  = LEVEL_W'(65536);
  localparam logic [TIME_W-1:0]  TIME_MAX = {TIME_W{1'b1}};

  // Envelope phases, in the order they are visited.
  typedef enum logic [PHASE_W-1:0] {PH_DRAW, PH_HOLD, PH_ERASE, PH_END} phase_t;

  // Register indexes; the byte address is four times the index. The spare
  // slot has no register behind it.
  typedef enum logic [1:0] {REG_DRAW, REG_HOLD, REG_ERASE, REG_SPARE} reg_idx_t;

endpackage

/* hdl/draw_hold_erase_envelope.sv */
// ----------------------------------------------------------------------------
// Draw/hold/erase envelope
// Four-phase timed envelope with ease-out-cubic draw and cubic erase shaping.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                      Payload
// s_*       in   s_tvalid / s_tready            s_tdata[15:0] advance (ms)
// m_*       out  m_tvalid / m_tready            m_tdata: [1:0] phase, [18:2] level
// APB       in   psel & penable & pwrite        0x0 draw, 0x4 hold, 0x8 erase
//
// A tick transaction is taken only while the sequencer is idle. A tick that
// needs a new level is accepted, passes the shared restoring divider (one
// quotient bit a cycle), hands the quotient over, passes the shared
// multiplier for square and cube and then the rounding step, loads the level
// and then loads the output register. A tick that only moves the timer or the
// phase goes from acceptance straight to the output step. The
// output register holds its result while m_tready is low; the next tick may
// be accepted meanwhile, and it waits in its final step until the register is
// free. Reset (rst, synchronous) returns to draw phase, timer and level zero,
// and all durations to 1000 ms.
// ----------------------------------------------------------------------------
`include "draw_hold_erase_envelope_defines.svh"

module draw_hold_erase_envelope (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dhe_pkg::ADDR_W-1:0]      paddr,
  input  logic [dhe_pkg::DATA_W-1:0]      pwdata,
  output logic [dhe_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  // Tick stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,   // [15:0] advance
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata    // [1:0] phase, [18:2] level, rest zero
);

  localparam int TW = dhe_pkg::TIME_W;
  localparam int DW = dhe_pkg::DUR_W;
  localparam int LW = dhe_pkg::LEVEL_W;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_CUBE, ST_OUT} state_t;

  state_t           state;
  dhe_pkg::phase_t  phase_reg;
  logic [TW-1:0]    phase_time;
  logic [LW-1:0]    level_reg;
  logic [DW-1:0]    draw_duration;
  logic [DW-1:0]    hold_duration;
  logic [DW-1:0]    erase_duration;

  logic             s_fire;
  logic             cfg_wr;
  logic [TW:0]      t_sum;
  logic [TW-1:0]    t_sat;
  logic [DW-1:0]    dur_cur;
  logic             below;
  logic [DW-1:0]    div_num;
  logic             div_start;
  logic             div_done;
  logic [LW-1:0]    div_quo;
  logic             cube_done;
  logic [LW-1:0]    cube_val;
  logic             out_free;
  logic             in_end;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign in_end   = (phase_reg == dhe_pkg::PH_END);

  // Register readback.
  always_comb begin
    case (paddr[3:2])
      dhe_pkg::REG_DRAW:  prdata = {{(dhe_pkg::DATA_W-DW){1'b0}}, draw_duration};
      dhe_pkg::REG_HOLD:  prdata = {{(dhe_pkg::DATA_W-DW){1'b0}}, hold_duration};
      dhe_pkg::REG_ERASE: prdata = {{(dhe_pkg::DATA_W-DW){1'b0}}, erase_duration};
      default:            prdata = '0;
    endcase
  end

  // Timer update with saturation, and the duration of the current phase.
  // End phase has no duration; it never leaves.
  always_comb begin
    t_sum = {1'b0, phase_time} + {{(TW+1-dhe_pkg::ADV_W){1'b0}}, s_tdata};
    t_sat = t_sum[TW] ? dhe_pkg::TIME_MAX : t_sum[TW-1:0];
    case (phase_reg)
      dhe_pkg::PH_DRAW:  dur_cur = draw_duration;
      dhe_pkg::PH_HOLD:  dur_cur = hold_duration;
      dhe_pkg::PH_ERASE: dur_cur = erase_duration;
      default:           dur_cur = '0;
    endcase
    below     = (t_sat < {1'b0, dur_cur});
    // Only used when below holds, so the difference fits the duration width.
    div_num   = dur_cur - t_sat[DW-1:0];
    div_start = s_fire && below &&
                (phase_reg == dhe_pkg::PH_DRAW || phase_reg == dhe_pkg::PH_ERASE);
  end

  dhe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dur_cur),
    .done  (div_done),
    .quo   (div_quo)
  );

  dhe_cube u_cube (
    .clk   (clk),
    .rst   (rst),
    .start (div_done),
    .ratio (div_quo),
    .done  (cube_done),
    .cube  (cube_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      phase_reg      <= dhe_pkg::PH_DRAW;
      phase_time     <= '0;
      level_reg      <= '0;
      draw_duration  <= DW'(1000);
      hold_duration  <= DW'(1000);
      erase_duration <= DW'(1000);
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          dhe_pkg::REG_DRAW:  draw_duration  <= pwdata[DW-1:0];
          dhe_pkg::REG_HOLD:  hold_duration  <= pwdata[DW-1:0];
          dhe_pkg::REG_ERASE: erase_duration <= pwdata[DW-1:0];
          default:            ;
        endcase
      end

      // The output register fills in the final step once it is free, and a
      // taken result empties it otherwise.
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            case (phase_reg)
              dhe_pkg::PH_DRAW, dhe_pkg::PH_ERASE: begin
                if (below) begin
                  phase_time <= t_sat;
                end else begin
                  // Phase is over: move on and drop any surplus time.
                  phase_reg  <= (phase_reg == dhe_pkg::PH_DRAW) ? dhe_pkg::PH_HOLD
                                                                 : dhe_pkg::PH_END;
                  phase_time <= '0;
                end
              end
              dhe_pkg::PH_HOLD: begin
                if (below) begin
                  phase_time <= t_sat;
                end else begin
                  phase_reg  <= dhe_pkg::PH_ERASE;
                  phase_time <= '0;
                end
              end
              default: phase_time <= t_sat;
            endcase
            state <= div_start ? ST_DIV : ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_CUBE;
          end
        end
        ST_CUBE: begin
          if (cube_done) begin
            // Draw rises as one minus the cube; erase falls as the cube.
            level_reg <= (phase_reg == dhe_pkg::PH_DRAW) ? dhe_pkg::ONE_Q16 - cube_val
                                                          : cube_val;
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_tdata <= {5'b0, level_reg, phase_reg};
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `DHE_ASSERT_NEXT(a_busy_after_accept, s_fire, !s_tready, "tick taken while busy")
  `DHE_ASSERT_SAME(a_ratio_range, div_done, div_quo <= dhe_pkg::ONE_Q16, "ratio above one")
  `DHE_ASSERT_SAME(a_level_range, m_tvalid, m_tdata[18:2] <= dhe_pkg::ONE_Q16, "level above one")
  `DHE_ASSERT_NEXT(a_end_holds, in_end, in_end, "end phase was left")

endmodule

/* hdl/dhe_div.sv */
// ----------------------------------------------------------------------------
// Envelope ratio divider
// Restoring divider, one quotient bit per cycle, computing
// floor(num * 65536 / den) for num <= den. Quotient is 17 bits.
// ----------------------------------------------------------------------------
module dhe_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [dhe_pkg::DUR_W-1:0]       num,
  input  logic [dhe_pkg::DUR_W-1:0]       den,
  output logic                            done,
  output logic [dhe_pkg::LEVEL_W-1:0]     quo
);

  localparam int QW   = dhe_pkg::LEVEL_W;
  localparam int CW   = $clog2(QW);
  localparam logic [CW-1:0] LAST = CW'(QW - 1);

  logic                  busy;
  logic                  first;
  logic [CW-1:0]         cnt;
  logic [QW-1:0]         rem;
  logic [dhe_pkg::DUR_W-1:0] den_r;
  logic [QW-1:0]         trial;
  logic [QW:0]           diff;
  logic                  ge;

  // The first step compares the numerator itself (quotient bit 16); later
  // steps shift a zero into the partial remainder.
  always_comb begin
    trial = first ? rem : {rem[QW-2:0], 1'b0};
    diff  = {1'b0, trial} - {2'b00, den_r};
    ge    = ~diff[QW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      first <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        first <= 1'b1;
        cnt   <= '0;
        rem   <= {1'b0, num};
        den_r <= den;
        quo   <= '0;
      end else if (busy) begin
        first <= 1'b0;
        rem   <= ge ? diff[QW-1:0] : trial;
        quo   <= {quo[QW-2:0], ge};
        cnt   <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/dhe_cube.sv */
// ----------------------------------------------------------------------------
// Envelope cube unit
// One registered multiplier used twice (square, then cube), followed by
// rounding of r^3 / 2^32 to nearest and a clamp to one.
// ----------------------------------------------------------------------------
module dhe_cube (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [dhe_pkg::LEVEL_W-1:0]     ratio,
  output logic                            done,
  output logic [dhe_pkg::LEVEL_W-1:0]     cube
);

  localparam int LW = dhe_pkg::LEVEL_W;
  localparam int SW = dhe_pkg::SQ_W;
  localparam int CW = dhe_pkg::CUBE_W;
  localparam logic [CW:0] ROUND = (CW+1)'(1) << 31;

  typedef enum logic [1:0] {C_IDLE, C_SQ, C_CU, C_RND} cstate_t;

  cstate_t         state;
  logic [LW-1:0]   ratio_r;
  logic [CW-1:0]   prod;
  logic [SW-1:0]   mul_a;
  logic [CW-1:0]   mul_p;
  logic [CW:0]     rounded;
  logic [CW-32:0]  scaled;

  // Shared multiplier: first r * r, then (r * r) * r. Both operands are
  // widened to the full cube width so the product keeps every bit.
  always_comb begin
    mul_a   = (state == C_SQ) ? {{(SW-LW){1'b0}}, ratio_r} : prod[SW-1:0];
    mul_p   = {{(CW-SW){1'b0}}, mul_a} * {{(CW-LW){1'b0}}, ratio_r};
    rounded = {1'b0, prod} + ROUND;
    scaled  = rounded[CW:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            ratio_r <= ratio;
            state   <= C_SQ;
          end
        end
        C_SQ: begin
          prod  <= mul_p;
          state <= C_CU;
        end
        C_CU: begin
          prod  <= mul_p;
          state <= C_RND;
        end
        C_RND: begin
          cube  <= (scaled > (CW-31)'(dhe_pkg::ONE_Q16)) ? dhe_pkg::ONE_Q16
                                                         : scaled[LW-1:0];
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

/* sim/tb_draw_hold_erase_envelope.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Draw/hold/erase envelope testbench
// Walks the envelope once through draw, hold, erase and end. Ticks go in on
// the input stream, and phase durations are changed over the register port
// while the block is idle. A scoreboard class tracks its own copy of the timer,
// phase and level, and it compares every result transaction with the oldest
// expected one. Both stream sides pause at random. In two stretches the result
// side holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_draw_hold_erase_envelope;

  typedef struct packed {
    logic [1:0]  phase;
    logic [16:0] level;
  } env_out_t;

  localparam int AW              = dhe_pkg::ADDR_W;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 30;
  localparam int TAIL_CYCLES     = 40;

  // Predicts the block one tick at a time and holds the results still owed.
  class envelope_scoreboard;
    logic [15:0]     draw_ms;
    logic [15:0]     hold_ms;
    logic [15:0]     erase_ms;
    dhe_pkg::phase_t phase_q;
    logic [16:0]     timer_q;
    logic [16:0]     level_q;
    env_out_t        pending_levels[$];
    int              errors;

    function new();
      draw_ms  = 16'd1000;
      hold_ms  = 16'd1000;
      erase_ms = 16'd1000;
      phase_q  = dhe_pkg::PH_DRAW;
      timer_q  = '0;
      level_q  = '0;
      errors   = 0;
    endfunction

    function void set_duration(dhe_pkg::reg_idx_t idx, logic [15:0] ms);
      case (idx)
        dhe_pkg::REG_DRAW:  draw_ms  = ms;
        dhe_pkg::REG_HOLD:  hold_ms  = ms;
        dhe_pkg::REG_ERASE: erase_ms = ms;
        default: ;
      endcase
    endfunction

    // (1 - t/d)^3 in Q1.16, the cube rounded to nearest. Only used with t < d.
    function logic [16:0] cube_of_remainder(logic [16:0] t, logic [15:0] d);
      logic [63:0] ratio;
      logic [63:0] cube;
      ratio = ((64'(d) - 64'(t)) << 16) / 64'(d);
      cube  = (ratio * ratio * ratio + 64'h8000_0000) >> 32;
      if (cube > 64'd65536) cube = 64'd65536;
      return cube[16:0];
    endfunction

    function void note_tick(logic [15:0] advance);
      logic [17:0] sum;
      env_out_t    entry;
      sum = 18'(timer_q) + 18'(advance);
      timer_q = (sum > 18'h1FFFF) ? 17'h1FFFF : sum[16:0];
      case (phase_q)
        dhe_pkg::PH_DRAW: begin
          if (timer_q < 17'(draw_ms)) begin
            level_q = 17'd65536 - cube_of_remainder(timer_q, draw_ms);
          end else begin
            phase_q = dhe_pkg::PH_HOLD;
            timer_q = '0;
          end
        end
        dhe_pkg::PH_HOLD: begin
          if (timer_q >= 17'(hold_ms)) begin
            phase_q = dhe_pkg::PH_ERASE;
            timer_q = '0;
          end
        end
        dhe_pkg::PH_ERASE: begin
          if (timer_q < 17'(erase_ms)) begin
            level_q = cube_of_remainder(timer_q, erase_ms);
          end else begin
            phase_q = dhe_pkg::PH_END;
            timer_q = '0;
          end
        end
        default: ;
      endcase
      entry.phase = phase_q;
      entry.level = level_q;
      pending_levels.insert(pending_levels.size(), entry);
    endfunction

    function void check_output(logic [23:0] data);
      env_out_t want;
      if (pending_levels.size() == 0) begin
        $error("result with no tick waiting: phase %0d level %0d", data[1:0], data[18:2]);
        errors++;
        return;
      end
      want = pending_levels.pop_front();
      if (data[1:0] !== want.phase) begin
        $error("phase: expected %0d, actual %0d", want.phase, data[1:0]);
        errors++;
      end
      if (data[18:2] !== want.level) begin
        $error("level: expected %0d, actual %0d", want.level, data[18:2]);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [dhe_pkg::ADDR_W-1:0]  paddr;
  logic [dhe_pkg::DATA_W-1:0]  pwdata;
  logic [dhe_pkg::DATA_W-1:0]  prdata;
  logic                        pready;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [15:0]                 s_tdata;   // [15:0] advance
  logic                        m_tvalid;
  logic                        m_tready;
  logic [23:0]                 m_tdata;   // [1:0] phase, [18:2] level, [23:19] zero

  envelope_scoreboard sb = new();

  // Pacing knobs shared by the two stream processes. A maximum gap of zero
  // gives a stretch with no idling on that side.
  int unsigned src_max_gap   = 17;
  int unsigned sink_max_gap  = 17;
  bit          sink_hold_off = 1'b0;
  int          stall_cycles  = 0;

  draw_hold_erase_envelope dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Every task below is entered and left just after a rising edge. Inputs are
  // driven with nonblocking assignments there, and handshakes are judged on
  // the values that were present before that edge.

  // Register write: a setup cycle, then the access cycle. The upper
  // half of the write data carries random bits, which the register drops.
  task automatic reg_write(input dhe_pkg::reg_idx_t idx, input logic [15:0] ms);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'({idx, 2'b00});
    pwdata  <= {16'($urandom), ms};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_duration(idx, ms);
  endtask

  // Offer one tick. With no gap drawn, tvalid simply stays high from the
  // previous transaction, so it is never lowered and raised in one step.
  task automatic send_tick(input logic [15:0] advance);
    int unsigned gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= advance;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_tick(advance);
  endtask

  // Stop offering ticks until every result has come back, then let the block
  // sit idle before the register port is touched.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_pacing();
    src_max_gap  = ($urandom_range(0, 3) == 0) ? 0 : 17;
    sink_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 17;
  endtask

  // Random walk along an easing curve. Each round sets a new duration a little
  // above the running timer and then advances in random steps that stop short
  // of it, so the level sweeps far up the curve without leaving the phase.
  task automatic ease_rounds(input dhe_pkg::reg_idx_t idx);
    int unsigned dur;
    int unsigned room;
    int unsigned step_max;
    for (int round = 0; round < 8; round++) begin
      settle();
      pick_pacing();
      dur = sb.timer_q + $urandom_range(64, 4000);
      if (dur > 65535) dur = 65535;
      reg_write(idx, 16'(dur));
      step_max = (dur - sb.timer_q) / 25 * $urandom_range(1, 3) + 1;
      for (int n = 0; n < 25; n++) begin
        room = dur - 1 - sb.timer_q;
        send_tick(16'($urandom_range(0, (step_max < room) ? step_max : room)));
      end
    end
  endtask

  // Result side: a random pause before each transaction, and once on request
  // a long hold-off while the tick side keeps offering.
  initial begin : result_sink
    int unsigned gap;
    m_tready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (sink_hold_off) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        sink_hold_off = 1'b0;
      end
      gap = $urandom_range(0, sink_max_gap);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_output(m_tdata);
    end
  end

  // Watchdog: too many cycles in a row with no transaction on any port.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Draw, directed. Reset durations first: a zero advance leaves the timer
    // at zero, so the full remainder cubes to one and the level stays zero.
    send_tick(16'd0);
    send_tick(16'd0);
    // Shortest legal draw, still at time zero.
    settle();
    reg_write(dhe_pkg::REG_DRAW, 16'd1);
    send_tick(16'd0);
    // Longest draw. The spare slot gets a value that would visibly bend the
    // curve if the write leaked into the draw register.
    settle();
    reg_write(dhe_pkg::REG_DRAW, 16'hFFFF);
    reg_write(dhe_pkg::REG_SPARE, 16'd3);
    send_tick(16'd1);

    // Draw, random rounds with the duration moved between them.
    ease_rounds(dhe_pkg::REG_DRAW);

    // End of the draw curve: one millisecond short of the longest duration the
    // cube rounds to zero and the level reaches exactly one.
    settle();
    reg_write(dhe_pkg::REG_DRAW, 16'hFFFF);
    send_tick(16'(65534 - sb.timer_q));
    send_tick(16'd0);
    // Cutting the duration to zero below the running timer ends draw on the
    // next tick without a new level.
    settle();
    reg_write(dhe_pkg::REG_DRAW, 16'd0);
    send_tick(16'd0);

    // Hold: the level must not move. The second round has the result side
    // hold off for a long stretch while ticks keep coming with no gaps, so
    // the block backs up and stalls the tick side.
    settle();
    reg_write(dhe_pkg::REG_HOLD, 16'hFFFF);
    for (int round = 0; round < 2; round++) begin
      settle();
      pick_pacing();
      if (round == 1) begin
        src_max_gap   = 0;
        sink_hold_off = 1'b1;
      end
      for (int n = 0; n < 20; n++) begin
        send_tick(16'($urandom_range(0, 1500)));
      end
    end
    // Zero hold with time already spent: the next tick, here the largest
    // advance, moves on to erase.
    settle();
    reg_write(dhe_pkg::REG_HOLD, 16'd0);
    send_tick(16'hFFFF);

    // Erase, directed, at the reset duration: time zero gives the full level,
    // and the last millisecond before the end gives zero.
    send_tick(16'd0);
    send_tick(16'd999);

    ease_rounds(dhe_pkg::REG_ERASE);

    settle();
    reg_write(dhe_pkg::REG_ERASE, 16'hFFFF);
    send_tick(16'(65534 - sb.timer_q));
    settle();
    reg_write(dhe_pkg::REG_ERASE, 16'd0);
    send_tick(16'd0);

    // End holds whatever comes. Advances over the full range drive the timer
    // into saturation, and register writes must change nothing.
    for (int round = 0; round < 4; round++) begin
      settle();
      pick_pacing();
      reg_write(dhe_pkg::reg_idx_t'($urandom_range(0, 3)), 16'($urandom));
      if (round == 2) sink_hold_off = 1'b1;
      for (int n = 0; n < 25; n++) begin
        send_tick(16'($urandom));
      end
    end

    s_tvalid <= 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_levels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/dhe_pkg.sv
hdl/dhe_div.sv
hdl/dhe_cube.sv
hdl/draw_hold_erase_envelope.sv
sim/tb_draw_hold_erase_envelope.sv
